FILE: rtl/core/rcfp_pkg.sv
// ----------------------------------------------------------------------------
// rcfp_pkg
// shared types, constants and the crc-8 byte update for the frame packer
// ----------------------------------------------------------------------------
package rcfp_pkg;

    localparam int CHANNELS      = 16;
    localparam int MAX_PAYLOAD   = 64;
    localparam int RESULT_LIMIT  = 4;
    localparam int IDX_W         = $clog2(RESULT_LIMIT);
    localparam int CNT_W         = $clog2(RESULT_LIMIT + 1);
    localparam int CHAN_BITS     = 11;
    localparam int PAYLOAD_BYTES = (CHANNELS * CHAN_BITS + 7) / 8;

    localparam logic [7:0]  DEST_RESET  = 8'hEE;
    localparam logic [7:0]  CHAN_TYPE   = 8'h16;
    localparam logic [7:0]  LEN_BYTE    = 8'(PAYLOAD_BYTES + 2);
    localparam logic [7:0]  CRC_POLY    = 8'hD5;
    localparam logic [10:0] CHAN_CENTER = 11'h3E0;
    localparam logic [10:0] CHAN_MAX    = 11'(2 * 11'h3E0);
    // 2^16 / 5 rounded up, exact for magnitudes up to 8192
    localparam logic [14:0] RECIP_5     = 15'd13108;

    // how the serializer treats a byte of the bundle
    typedef enum logic [1:0] {
        BK_START   = 2'd0,   // address byte, clears the running crc
        BK_PLAIN   = 2'd1,   // not covered by the crc
        BK_COVERED = 2'd2,   // folded into the running crc
        BK_CRC     = 2'd3    // running crc goes out here, closes the frame
    } byte_kind_t;

    typedef struct packed {
        logic [7:0] data;
        byte_kind_t kind;
    } entry_t;

    typedef struct packed {
        logic [CNT_W-1:0]               cnt;
        entry_t [RESULT_LIMIT-1:0]      ent;
    } bundle_t;

    typedef struct packed {
        logic              op;
        logic signed [11:0] chan_value;
        logic [7:0]        data_byte;
        logic [7:0]        command;
        logic [6:0]        data_count;
    } item_t;

    function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

endpackage

FILE: rtl/core/rcfp_item_reg.sv
// ----------------------------------------------------------------------------
// rcfp_item_reg
// input register holding one accepted item until the packer takes it
// ----------------------------------------------------------------------------
module rcfp_item_reg (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  rcfp_pkg::item_t in_item,
    input  logic            take,
    output logic            item_valid,
    output rcfp_pkg::item_t item
);

    logic            valid_reg;
    logic            valid_next;
    rcfp_pkg::item_t item_reg;

    assign in_ready   = !valid_reg || take;
    assign valid_next = (in_valid && in_ready) ? 1'b1 : (take ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

FILE: rtl/core/rcfp_packer.sv
// ----------------------------------------------------------------------------
// rcfp_packer
// frame state and the byte bundle that one item produces
// ----------------------------------------------------------------------------
module rcfp_packer (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    input  rcfp_pkg::item_t   item,
    input  logic [7:0]        dest,
    output logic              take,
    output logic              bundle_valid,
    input  logic              bundle_ready,
    output rcfp_pkg::bundle_t bundle
);

    logic [6:0] acc_reg, acc_next;
    logic [2:0] held_reg, held_next;
    logic [6:0] pos_reg, pos_next;
    logic       mode_reg, mode_next;
    logic [6:0] pc_reg, pc_next;

    logic        start;
    logic        mode_eff;
    logic [6:0]  acc_eff;
    logic [2:0]  held_eff;
    logic [6:0]  dc;
    logic [13:0] v4;
    logic [13:0] mag;
    logic [28:0] prod;
    logic [10:0] quot;
    logic [11:0] up_sum;
    logic [10:0] scaled;
    logic [17:0] word;
    logic [4:0]  total;
    logic        two;
    logic [2:0]  rem;
    logic [6:0]  residue;
    rcfp_pkg::bundle_t b;

    function automatic rcfp_pkg::bundle_t push(input rcfp_pkg::bundle_t bi,
                                               input logic [7:0] d,
                                               input rcfp_pkg::byte_kind_t k);
        rcfp_pkg::bundle_t bo;
        bo = bi;
        if (bo.cnt < rcfp_pkg::CNT_W'(rcfp_pkg::RESULT_LIMIT))
        begin
            bo.ent[bo.cnt[rcfp_pkg::IDX_W-1:0]].data = d;
            bo.ent[bo.cnt[rcfp_pkg::IDX_W-1:0]].kind = k;
            bo.cnt = bo.cnt + 1'b1;
        end
        return bo;
    endfunction

    assign take         = item_valid && bundle_ready;
    assign bundle_valid = item_valid;
    assign bundle       = b;

    // channel scaling: 992 + trunc(v*4/5), clamped to 0..1984
    always_comb
    begin
        v4   = {item.chan_value, 2'b00};
        mag  = v4[13] ? (~v4 + 14'd1) : v4;
        prod = 29'(mag) * 29'(rcfp_pkg::RECIP_5);
        quot = prod[26:16];
        up_sum = 12'(rcfp_pkg::CHAN_CENTER) + 12'(quot);
        if (v4[13])
        begin
            scaled = (quot > rcfp_pkg::CHAN_CENTER) ? 11'd0 : (rcfp_pkg::CHAN_CENTER - quot);
        end
        else
        begin
            scaled = (up_sum > 12'(rcfp_pkg::CHAN_MAX)) ? rcfp_pkg::CHAN_MAX : up_sum[10:0];
        end
    end

    always_comb
    begin
        start    = (pos_reg == 7'd0);
        mode_eff = start ? item.op : mode_reg;
        acc_eff  = start ? 7'd0 : acc_reg;
        held_eff = start ? 3'd0 : held_reg;

        word    = 18'(acc_eff) | (18'(scaled) << held_eff);
        total   = 5'(held_eff) + 5'(rcfp_pkg::CHAN_BITS);
        two     = (total >= 5'd16);
        rem     = two ? 3'(total - 5'd16) : 3'(total - 5'd8);
        residue = two ? {5'd0, word[17:16]} : word[14:8];

        dc = item.data_count;
        if (dc == 7'd0)
        begin
            dc = 7'd1;
        end
        else if (dc > 7'(rcfp_pkg::MAX_PAYLOAD))
        begin
            dc = 7'(rcfp_pkg::MAX_PAYLOAD);
        end

        acc_next  = acc_reg;
        held_next = held_reg;
        pos_next  = pos_reg;
        mode_next = mode_eff;
        pc_next   = pc_reg;
        b         = '0;

        if (start)
        begin
            b = push(b, dest, rcfp_pkg::BK_START);
            if (item.op)
            begin
                b = push(b, 8'(dc) + 8'd2, rcfp_pkg::BK_PLAIN);
                b = push(b, item.command, rcfp_pkg::BK_COVERED);
            end
            else
            begin
                b = push(b, rcfp_pkg::LEN_BYTE, rcfp_pkg::BK_PLAIN);
                b = push(b, rcfp_pkg::CHAN_TYPE, rcfp_pkg::BK_COVERED);
            end
        end

        if (start && item.op)
        begin
            // command header item: data byte ignored
            pc_next  = dc;
            pos_next = 7'd1;
        end
        else if (mode_eff)
        begin
            b = push(b, item.data_byte, rcfp_pkg::BK_COVERED);
            if (pos_reg >= pc_reg)
            begin
                b = push(b, 8'd0, rcfp_pkg::BK_CRC);
                pos_next = 7'd0;
            end
            else
            begin
                pos_next = pos_reg + 7'd1;
            end
        end
        else
        begin
            b = push(b, word[7:0], rcfp_pkg::BK_COVERED);
            if (two)
            begin
                b = push(b, word[15:8], rcfp_pkg::BK_COVERED);
            end
            if (pos_reg >= 7'(rcfp_pkg::CHANNELS - 1))
            begin
                if (rem != 3'd0)
                begin
                    b = push(b, {1'b0, residue}, rcfp_pkg::BK_COVERED);
                end
                b = push(b, 8'd0, rcfp_pkg::BK_CRC);
                acc_next  = 7'd0;
                held_next = 3'd0;
                pos_next  = 7'd0;
            end
            else
            begin
                acc_next  = residue;
                held_next = rem;
                pos_next  = pos_reg + 7'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg  <= 7'd0;
            held_reg <= 3'd0;
            pos_reg  <= 7'd0;
            mode_reg <= 1'b0;
            pc_reg   <= 7'd0;
        end
        else if (take)
        begin
            acc_reg  <= acc_next;
            held_reg <= held_next;
            pos_reg  <= pos_next;
            mode_reg <= mode_next;
            pc_reg   <= pc_next;
        end
    end

endmodule

FILE: rtl/core/rcfp_serializer.sv
// ----------------------------------------------------------------------------
// rcfp_serializer
// result register: sends a bundle one byte per cycle while out_ready is high and keeps the crc
// ----------------------------------------------------------------------------
module rcfp_serializer (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   bundle_valid,
    output logic                   bundle_ready,
    input  rcfp_pkg::bundle_t      bundle,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [7:0]             out_data,
    output logic                   out_last,
    output rcfp_pkg::byte_kind_t   cur_kind
);

    rcfp_pkg::bundle_t           bundle_reg;
    logic                        valid_reg, valid_next;
    logic [rcfp_pkg::IDX_W-1:0]  rd_reg, rd_next;
    logic [7:0]                  crc_reg, crc_next;

    rcfp_pkg::entry_t cur;
    logic             fire;
    logic             last;
    logic             load;

    assign cur          = bundle_reg.ent[rd_reg];
    assign fire         = valid_reg && out_ready;
    assign last         = ((rcfp_pkg::CNT_W'(rd_reg) + 1'b1) == bundle_reg.cnt);
    assign bundle_ready = !valid_reg || (fire && last);
    assign load         = bundle_valid && bundle_ready;

    always_comb
    begin
        valid_next = valid_reg;
        rd_next    = rd_reg;
        crc_next   = crc_reg;
        if (fire)
        begin
            case (cur.kind)
                rcfp_pkg::BK_START:   crc_next = 8'd0;
                rcfp_pkg::BK_COVERED: crc_next = rcfp_pkg::crc8_update(crc_reg, cur.data);
                default:              crc_next = crc_reg;
            endcase
            rd_next = rd_reg + 1'b1;
            if (last)
            begin
                valid_next = 1'b0;
            end
        end
        if (load)
        begin
            valid_next = 1'b1;
            rd_next    = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            rd_reg    <= '0;
            crc_reg   <= 8'd0;
        end
        else
        begin
            valid_reg <= valid_next;
            rd_reg    <= rd_next;
            crc_reg   <= crc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            bundle_reg <= bundle;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = (cur.kind == rcfp_pkg::BK_CRC) ? crc_reg : cur.data;
    assign out_last  = (cur.kind == rcfp_pkg::BK_CRC);
    assign cur_kind  = cur.kind;

endmodule

FILE: rtl/core/rc_channel_frame_packer_unit.sv
// ----------------------------------------------------------------------------
// rc_channel_frame_packer_unit
// radio-link frame builder: packed 11-bit channel frames and command frames
// ----------------------------------------------------------------------------
// each accepted item yields one to four frame bytes (four on a channel frame's
// first item, usually one or two later), which leave one byte per cycle on the
// master stream while m_axis_tready is high. the single-lane output serializer
// takes the next bundle only as the last byte of the previous one leaves. an
// item goes from the input register through the packing logic into the result
// register, and the input register can accept the next item while the previous
// bundle is still draining. the first item of a frame picks the frame kind from
// tuser. the crc-8 (poly 0xd5) is kept at the output, one byte per cycle as the
// bytes leave, over every byte after the length byte. there is no clearing pass
// after reset.
module rc_channel_frame_packer_unit (
    input  logic        clk,
    input  logic        rst_n,

    // configuration: destination address
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data,

    // input items
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // chan_value [11:0], data_byte [19:12], command [27:20],
    // data_count [34:28], zero [39:35]
    input  logic [39:0] s_axis_tdata,
    // op [0]
    input  logic        s_axis_tuser,

    // frame bytes
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // out_byte [7:0]
    output logic [7:0]  m_axis_tdata,
    // frame_end: high on the crc byte
    output logic        m_axis_tlast
);

    logic [7:0]            dest_reg;
    rcfp_pkg::item_t       in_item;
    rcfp_pkg::item_t       item;
    logic                  item_valid;
    logic                  take;
    logic                  bundle_valid;
    logic                  bundle_ready;
    rcfp_pkg::bundle_t     bundle;
    rcfp_pkg::byte_kind_t  cur_kind;

    // register write is always taken
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dest_reg <= rcfp_pkg::DEST_RESET;
        end
        else if (cfg_valid)
        begin
            dest_reg <= cfg_data;
        end
    end

    // unpack the stream payload into item fields
    always_comb
    begin
        in_item.op         = s_axis_tuser;
        in_item.chan_value = s_axis_tdata[11:0];
        in_item.data_byte  = s_axis_tdata[19:12];
        in_item.command    = s_axis_tdata[27:20];
        in_item.data_count = s_axis_tdata[34:28];
    end

    // input register
    rcfp_item_reg u_item (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_item    (in_item),
        .take       (take),
        .item_valid (item_valid),
        .item       (item)
    );

    // scaling, bit packing and frame sequencing
    rcfp_packer u_packer (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item         (item),
        .dest         (dest_reg),
        .take         (take),
        .bundle_valid (bundle_valid),
        .bundle_ready (bundle_ready),
        .bundle       (bundle)
    );

    // result register, byte serializer and crc
    rcfp_serializer u_ser (
        .clk          (clk),
        .rst_n        (rst_n),
        .bundle_valid (bundle_valid),
        .bundle_ready (bundle_ready),
        .bundle       (bundle),
        .out_valid    (m_axis_tvalid),
        .out_ready    (m_axis_tready),
        .out_data     (m_axis_tdata),
        .out_last     (m_axis_tlast),
        .cur_kind     (cur_kind)
    );

    // a held item is not dropped or changed before the packer takes it
    a_item_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && !take) |=> (item_valid && $stable(item)))
        else $error("held item lost or changed");

    // every bundle handed over carries one to four bytes
    a_bundle_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        take |-> ((bundle.cnt != '0) &&
                  (bundle.cnt <= rcfp_pkg::CNT_W'(rcfp_pkg::RESULT_LIMIT))))
        else $error("bundle byte count out of range");

    // a byte that follows a closing crc opens a new frame
    a_frame_start: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=>
            (!m_axis_tvalid || (cur_kind == rcfp_pkg::BK_START)))
        else $error("frame did not restart with the address byte");

endmodule

FILE: sim/rcfp_frame_checker.sv
// ----------------------------------------------------------------------------
// rcfp_frame_checker
// watches the frame packer's channels, predicts every frame byte and compares
// ----------------------------------------------------------------------------
// each accepted input item is turned into the frame bytes it completes, which
// wait in order until the byte stream hands them over; the address register
// is followed through the configuration channel
module rcfp_frame_checker (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [7:0]  cfg_data,

    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [39:0] s_tdata,
    input  logic        s_tuser,

    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [7:0]  m_tdata,
    input  logic        m_tlast,

    output int          error_count,
    output int          pending,
    output int          bytes_checked,
    output int          frames_checked
);

    typedef struct packed {
        logic [7:0] value;
        logic       last;
    } frame_byte_t;

    frame_byte_t expected_bytes [$];

    // predictor state
    logic [7:0]  dest_addr;
    logic [17:0] bit_pool;
    int          pool_bits;
    logic [6:0]  slot;
    logic        cmd_mode;
    logic [6:0]  cmd_len;
    logic [7:0]  frame_crc;
    int          item_bytes;

    // crc-8, poly 0xd5, one message bit at a time, msb first
    function automatic logic [7:0] crc_fold(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        logic       fb;
        c = crc;
        for (int i = 7; i >= 0; i--)
        begin
            fb = c[7] ^ b[i];
            c  = {c[6:0], 1'b0};
            if (fb)
                c = c ^ rcfp_pkg::CRC_POLY;
        end
        return c;
    endfunction

    // an item yields at most four bytes, the rest are dropped
    task automatic push_byte(input logic [7:0] b, input logic last);
        if (item_bytes < rcfp_pkg::RESULT_LIMIT)
        begin
            expected_bytes.push_back(frame_byte_t'{b, last});
            item_bytes++;
        end
    endtask

    task automatic push_covered(input logic [7:0] b);
        frame_crc = crc_fold(frame_crc, b);
        push_byte(b, 1'b0);
    endtask

    task automatic predict_frame_bytes(input logic op, input logic [39:0] fields);
        int         level;
        logic [6:0] count;
        item_bytes = 0;
        if (slot == '0)
        begin
            // frame start: kind is latched here
            cmd_mode  = op;
            frame_crc = '0;
            bit_pool  = '0;
            pool_bits = 0;
            push_byte(dest_addr, 1'b0);
            if (cmd_mode)
            begin
                count = fields[34:28];
                if (count == '0)
                    count = 7'd1;
                if (count > rcfp_pkg::MAX_PAYLOAD)
                    count = 7'(rcfp_pkg::MAX_PAYLOAD);
                cmd_len = count;
                push_byte(8'(count) + 8'd2, 1'b0);
                push_covered(fields[27:20]);
                slot = 7'd1;
                return;
            end
            push_byte(rcfp_pkg::LEN_BYTE, 1'b0);
            push_covered(rcfp_pkg::CHAN_TYPE);
        end

        if (cmd_mode)
        begin
            push_covered(fields[19:12]);
            if (slot >= cmd_len)
            begin
                push_byte(frame_crc, 1'b1);
                slot = '0;
            end
            else
                slot = slot + 7'd1;
            return;
        end

        // channel value: scale, clamp, append 11 bits lsb first
        level = $signed(fields[11:0]);
        level = int'(rcfp_pkg::CHAN_CENTER) + (level * 4) / 5;
        if (level < 0)
            level = 0;
        if (level > 2 * int'(rcfp_pkg::CHAN_CENTER))
            level = 2 * int'(rcfp_pkg::CHAN_CENTER);
        bit_pool  = bit_pool | (18'(level) << pool_bits);
        pool_bits = pool_bits + rcfp_pkg::CHAN_BITS;
        while (pool_bits >= 8)
        begin
            push_covered(bit_pool[7:0]);
            bit_pool  = bit_pool >> 8;
            pool_bits = pool_bits - 8;
        end
        if (int'(slot) + 1 >= rcfp_pkg::CHANNELS)
        begin
            if (pool_bits > 0)
                push_covered(bit_pool[7:0]);
            push_byte(frame_crc, 1'b1);
            bit_pool  = '0;
            pool_bits = 0;
            slot      = '0;
        end
        else
            slot = slot + 7'd1;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        frame_byte_t head;
        if (!rst_n)
        begin
            expected_bytes.delete();
            dest_addr      = rcfp_pkg::DEST_RESET;
            bit_pool       = '0;
            pool_bits      = 0;
            slot           = '0;
            cmd_mode       = 1'b0;
            cmd_len        = '0;
            frame_crc      = '0;
            error_count    = 0;
            pending        = 0;
            bytes_checked  = 0;
            frames_checked = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                dest_addr = cfg_data;

            if (s_tvalid && s_tready)
                predict_frame_bytes(s_tuser, s_tdata);

            if (m_tvalid && m_tready)
            begin
                if (expected_bytes.size() == 0)
                begin
                    $error("frame byte 0x%02h (last %0b) with nothing expected",
                           m_tdata, m_tlast);
                    error_count++;
                end
                else
                begin
                    head = expected_bytes.pop_front();
                    if (m_tdata !== head.value)
                    begin
                        $error("out_byte: expected 0x%02h, got 0x%02h",
                               head.value, m_tdata);
                        error_count++;
                    end
                    if (m_tlast !== head.last)
                    begin
                        $error("frame_end: expected %0b, got %0b", head.last, m_tlast);
                        error_count++;
                    end
                    bytes_checked++;
                    if (head.last)
                        frames_checked++;
                end
            end
            pending = expected_bytes.size();
        end
    end

endmodule

FILE: sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// regression for the radio-link frame packer
// ----------------------------------------------------------------------------
// drives channel and command frames into the packer, with a directed opening
// (clamp edges, count limits, extreme bytes) and then random frames in four
// phases, each under its own destination address; a separate checker predicts
// every frame byte and counts mismatches, this module gives the verdict
module tb_top;

    localparam logic OP_CHANNEL     = 1'b0;
    localparam logic OP_COMMAND     = 1'b1;
    localparam int   HOLD_CYCLES    = 300;
    localparam int   WATCHDOG_LIMIT = 3000;

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;

    logic        cfg_valid     = 1'b0;
    logic        cfg_ready;
    logic [7:0]  cfg_data      = '0;

    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata  = '0;
    logic        s_axis_tuser  = 1'b0;

    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;
    logic        m_axis_tlast;

    // from the checker
    int error_count;
    int pending;
    int bytes_checked;
    int frames_checked;

    // pacing controls for the sender (tx_steady) and the receiver (rx_steady, hold_req)
    bit tx_steady = 1'b0;
    bit rx_steady = 1'b0;
    bit hold_req  = 1'b0;

    int items_sent  = 0;
    int chan_frames = 0;
    int cmd_frames  = 0;
    int cfg_writes  = 0;
    int idle_cycles = 0;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    rc_channel_frame_packer_unit DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    rcfp_frame_checker checker_i (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .s_tvalid       (s_axis_tvalid),
        .s_tready       (s_axis_tready),
        .s_tdata        (s_axis_tdata),
        .s_tuser        (s_axis_tuser),
        .m_tvalid       (m_axis_tvalid),
        .m_tready       (m_axis_tready),
        .m_tdata        (m_axis_tdata),
        .m_tlast        (m_axis_tlast),
        .error_count    (error_count),
        .pending        (pending),
        .bytes_checked  (bytes_checked),
        .frames_checked (frames_checked)
    );

    // mostly no gap, often a short one, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // channel values for the directed frame: range ends, both clamp edges,
    // center, and small values where the truncation toward zero shows
    function automatic logic [11:0] edge_value(input int k);
        case (k)
            0:       return 12'(-2048);
            1:       return 12'(2047);
            2:       return 12'(-1242);
            3:       return 12'(-1240);
            4:       return 12'(1240);
            5:       return 12'(1242);
            6:       return 12'(0);
            7:       return 12'(-1);
            8:       return 12'(1);
            9:       return 12'(-4);
            10:      return 12'(4);
            11:      return 12'(-6);
            12:      return 12'(6);
            13:      return 12'(-1024);
            14:      return 12'(1024);
            default: return 12'(-3);
        endcase
    endfunction

    // offer one item and hold it until the input register accepts it
    // tdata: chan_value [11:0], data_byte [19:12], command [27:20], data_count [34:28]
    task automatic offer_item(input logic op, input logic [11:0] chan, input logic [7:0] data,
                              input logic [7:0] cmd, input logic [6:0] count);
        int gap;
        gap = tx_steady ? 0 : pick_gap();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {5'b0, count, cmd, data, chan};
        do @(posedge clk); while (!s_axis_tready);
        items_sent++;
    endtask

    // one item per channel; op and the command fields are don't-care after item 0
    task automatic send_channel_frame(input bit edge_set);
        logic [11:0] v;
        for (int k = 0; k < rcfp_pkg::CHANNELS; k++)
        begin
            if (edge_set)
                v = edge_value(k);
            else if ($urandom_range(0, 4) == 0)
                v = 12'($urandom);
            else
                v = 12'($urandom_range(0, 2048) - 1024);
            offer_item(k == 0 ? OP_CHANNEL : 1'($urandom), v, 8'($urandom),
                       8'($urandom), 7'($urandom));
        end
        chan_frames++;
    endtask

    // header item, then as many data items as the count comes to after limiting;
    // fill below zero means random data bytes
    task automatic send_command_frame(input logic [6:0] count, input logic [7:0] cmd,
                                      input int fill);
        int n;
        n = (count == 0) ? 1 :
            ((count > rcfp_pkg::MAX_PAYLOAD) ? rcfp_pkg::MAX_PAYLOAD : int'(count));
        offer_item(OP_COMMAND, 12'($urandom), 8'($urandom), cmd, count);
        for (int k = 0; k < n; k++)
            offer_item(1'($urandom), 12'($urandom), (fill < 0) ? 8'($urandom) : 8'(fill),
                       8'($urandom), 7'($urandom));
        cmd_frames++;
    endtask

    task automatic run_random_frames(input int item_goal);
        int         r;
        logic [6:0] count;
        while (items_sent < item_goal)
        begin
            if ($urandom_range(0, 9) < 4)
                send_channel_frame(1'b0);
            else
            begin
                // mostly short payloads, a few at or beyond the limit, some zero
                r = $urandom_range(0, 99);
                if (r < 60)
                    count = 7'($urandom_range(1, 8));
                else if (r < 75)
                    count = 7'($urandom_range(9, 63));
                else if (r < 85)
                    count = 7'(rcfp_pkg::MAX_PAYLOAD);
                else if (r < 92)
                    count = 7'd0;
                else
                    count = 7'($urandom_range(65, 127));
                send_command_frame(count, 8'($urandom), -1);
            end
        end
    endtask

    // sender stops and waits until every predicted byte has been taken
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (4) @(posedge clk);
    endtask

    // address register is only written while the packer is idle
    task automatic write_dest(input logic [7:0] addr);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_data  <= addr;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        cfg_writes++;
    endtask

    // receiver: random gaps after taken bytes, or one long hold-off on request
    initial
    begin
        int rx_gap;
        rx_gap = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
                m_axis_tready <= 1'b1;
            end
            else if (rx_gap > 0)
            begin
                m_axis_tready <= 1'b0;
                rx_gap--;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                if (!rx_steady && m_axis_tvalid && m_axis_tready)
                    rx_gap = pick_gap();
            end
        end
    end

    // watchdog: too long without any handshake on any channel
    initial
    begin
        @(posedge rst_n);
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("no progress for %0d cycles, %0d bytes still expected",
                 WATCHDOG_LIMIT, pending);
        $display("rc_channel_frame_packer_unit regression: fail");
        $finish;
    end

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed opening under the reset address
        send_channel_frame(1'b1);
        send_command_frame(7'd0, 8'h00, 255);
        send_command_frame(7'd1, 8'hFF, 0);
        send_command_frame(7'd3, 8'hA5, -1);

        // phase a: lowest address, gaps on both sides
        write_dest(8'h00);
        run_random_frames(90);

        // phase b: highest address, no idling anywhere
        write_dest(8'hFF);
        tx_steady = 1'b1;
        rx_steady = 1'b1;
        run_random_frames(150);
        rx_steady = 1'b0;

        // phase c: random address, receiver holds off while the sender keeps
        // offering, so the packer fills and pushes back
        write_dest(8'($urandom_range(1, 254)));
        hold_req = 1'b1;
        run_random_frames(210);
        tx_steady = 1'b0;

        // phase d: back to the reset address
        write_dest(rcfp_pkg::DEST_RESET);
        run_random_frames(270);

        drain_results();
        $display("%0d items in %0d channel and %0d command frames",
                 items_sent, chan_frames, cmd_frames);
        $display("%0d bytes and %0d frames checked, %0d address writes", bytes_checked,
                 frames_checked, cfg_writes);
        $display("gapped and steady pacing, one %0d-cycle output hold-off", HOLD_CYCLES);
        if (error_count == 0 && pending == 0)
            $display("rc_channel_frame_packer_unit regression: pass");
        else
            $display("rc_channel_frame_packer_unit regression: fail");
        $finish;
    end

endmodule
